// ----- design/ebalu_pkg.sv -----
// Shared types and codes for the 8-bit CPU ALU with flags.
// Holds the transfer payload structs, opcode codes and flag bit positions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ebalu_pkg;

    localparam logic [4:0] OP_ADD     = 5'd0;
    localparam logic [4:0] OP_ADC     = 5'd1;
    localparam logic [4:0] OP_SUB     = 5'd2;
    localparam logic [4:0] OP_SBC     = 5'd3;
    localparam logic [4:0] OP_AND     = 5'd4;
    localparam logic [4:0] OP_XOR     = 5'd5;
    localparam logic [4:0] OP_OR      = 5'd6;
    localparam logic [4:0] OP_CP      = 5'd7;
    localparam logic [4:0] OP_INC     = 5'd8;
    localparam logic [4:0] OP_DEC     = 5'd9;
    localparam logic [4:0] OP_CPL     = 5'd10;
    localparam logic [4:0] OP_CCF     = 5'd11;
    localparam logic [4:0] OP_SCF     = 5'd12;
    localparam logic [4:0] OP_RLC     = 5'd13;
    localparam logic [4:0] OP_RRC     = 5'd14;
    localparam logic [4:0] OP_RL      = 5'd15;
    localparam logic [4:0] OP_RR      = 5'd16;
    localparam logic [4:0] OP_SLA     = 5'd17;
    localparam logic [4:0] OP_SRA     = 5'd18;
    localparam logic [4:0] OP_SRL     = 5'd19;
    localparam logic [4:0] OP_SWAP    = 5'd20;
    localparam logic [4:0] OP_BIT     = 5'd21;
    localparam logic [4:0] OP_RES     = 5'd22;
    localparam logic [4:0] OP_SET     = 5'd23;
    localparam logic [4:0] OP_ADD16   = 5'd24;
    localparam logic [4:0] OP_ADD_SP  = 5'd25;
    localparam logic [4:0] OP_INC16   = 5'd26;
    localparam logic [4:0] OP_DEC16   = 5'd27;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [4:0]        opcode;
        logic [7:0]        acc;
        logic [7:0]        operand;
        logic [2:0]        bit_index;
        logic [15:0]       wide_base;
        logic [15:0]       wide_addend;
        logic signed [7:0] offset;
        logic [3:0]        flags_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] word_result;
        logic [3:0]  flags_out;
        logic        writes_back;
    } t_out_item;

endpackage

`default_nettype wire

// ----- design/ebalu_exec.sv -----
// Combinational ALU datapath: one operation, result bytes and new flags.
// Depends on ebalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebalu_exec (
    input  ebalu_pkg::t_in_item  i_item,
    output ebalu_pkg::t_out_item o_item
);

    always_comb begin
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  off_u;
        logic [3:0]  fi;
        logic        cin;
        logic        t;
        logic [7:0]  mask;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [7:0]  b;
        logic [15:0] w;
        logic [3:0]  f;
        logic        wr;

        a     = i_item.acc;
        x     = i_item.operand;
        off_u = $unsigned(i_item.offset);
        fi    = i_item.flags_in;
        cin   = fi[ebalu_pkg::FLAG_C];
        t     = 1'b0;
        mask  = 8'b1 << i_item.bit_index;
        s9    = '0;
        s5    = '0;
        s17   = '0;
        s13   = '0;
        b     = '0;
        w     = '0;
        f     = fi;
        wr    = 1'b1;

        case (i_item.opcode)
            ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
                t  = (i_item.opcode == ebalu_pkg::OP_ADC) ? cin : 1'b0;
                s9 = {1'b0, a} + {1'b0, x} + {8'd0, t};
                s5 = {1'b0, a[3:0]} + {1'b0, x[3:0]} + {4'd0, t};
                b  = s9[7:0];
                f  = {b == 8'd0, 1'b0, s5[4], s9[8]};
            end
            ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
                t  = (i_item.opcode == ebalu_pkg::OP_SBC) ? cin : 1'b0;
                s9 = {1'b0, a} - {1'b0, x} - {8'd0, t};
                s5 = {1'b0, a[3:0]} - {1'b0, x[3:0]} - {4'd0, t};
                b  = s9[7:0];
                f  = {b == 8'd0, 1'b1, s5[4], s9[8]};
                wr = (i_item.opcode != ebalu_pkg::OP_CP);
            end
            ebalu_pkg::OP_AND: begin
                b = a & x;
                f = {b == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            ebalu_pkg::OP_XOR: begin
                b = a ^ x;
                f = {b == 8'd0, 3'b000};
            end
            ebalu_pkg::OP_OR: begin
                b = a | x;
                f = {b == 8'd0, 3'b000};
            end
            ebalu_pkg::OP_INC: begin
                b = x + 8'd1;
                f = {b == 8'd0, 1'b0, x[3:0] == 4'hf, cin};
            end
            ebalu_pkg::OP_DEC: begin
                b = x - 8'd1;
                f = {b == 8'd0, 1'b1, x[3:0] == 4'h0, cin};
            end
            ebalu_pkg::OP_CPL: begin
                b = ~a;
                f = {fi[ebalu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
            end
            ebalu_pkg::OP_CCF: begin
                b = a;
                f = {fi[ebalu_pkg::FLAG_Z], 1'b0, 1'b0, ~cin};
            end
            ebalu_pkg::OP_SCF: begin
                b = a;
                f = {fi[ebalu_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
            end
            ebalu_pkg::OP_RLC: begin
                b = {x[6:0], x[7]};
                f = {b == 8'd0, 2'b00, x[7]};
            end
            ebalu_pkg::OP_RRC: begin
                b = {x[0], x[7:1]};
                f = {b == 8'd0, 2'b00, x[0]};
            end
            ebalu_pkg::OP_RL: begin
                b = {x[6:0], cin};
                f = {b == 8'd0, 2'b00, x[7]};
            end
            ebalu_pkg::OP_RR: begin
                b = {cin, x[7:1]};
                f = {b == 8'd0, 2'b00, x[0]};
            end
            ebalu_pkg::OP_SLA: begin
                b = {x[6:0], 1'b0};
                f = {b == 8'd0, 2'b00, x[7]};
            end
            ebalu_pkg::OP_SRA: begin
                b = {x[7], x[7:1]};
                f = {b == 8'd0, 2'b00, x[0]};
            end
            ebalu_pkg::OP_SRL: begin
                b = {1'b0, x[7:1]};
                f = {b == 8'd0, 2'b00, x[0]};
            end
            ebalu_pkg::OP_SWAP: begin
                b = {x[3:0], x[7:4]};
                f = {b == 8'd0, 3'b000};
            end
            ebalu_pkg::OP_BIT: begin
                b  = x;
                wr = 1'b0;
                f  = {(x & mask) == 8'd0, 1'b0, 1'b1, cin};
            end
            ebalu_pkg::OP_RES: begin
                b = x & ~mask;
            end
            ebalu_pkg::OP_SET: begin
                b = x | mask;
            end
            ebalu_pkg::OP_ADD16: begin
                s17 = {1'b0, i_item.wide_base} + {1'b0, i_item.wide_addend};
                s13 = {1'b0, i_item.wide_base[11:0]} + {1'b0, i_item.wide_addend[11:0]};
                w   = s17[15:0];
                f   = {fi[ebalu_pkg::FLAG_Z], 1'b0, s13[12], s17[16]};
            end
            ebalu_pkg::OP_ADD_SP: begin
                w  = i_item.wide_base + {{8{off_u[7]}}, off_u};
                s9 = {1'b0, i_item.wide_base[7:0]} + {1'b0, off_u};
                s5 = {1'b0, i_item.wide_base[3:0]} + {1'b0, off_u[3:0]};
                f  = {2'b00, s5[4], s9[8]};
            end
            ebalu_pkg::OP_INC16: begin
                w = i_item.wide_base + 16'd1;
            end
            ebalu_pkg::OP_DEC16: begin
                w = i_item.wide_base - 16'd1;
            end
            default: begin
                wr = 1'b0;
            end
        endcase

        o_item.byte_result = b;
        o_item.word_result = w;
        o_item.flags_out   = f;
        o_item.writes_back = wr;
    end

endmodule

`default_nettype wire

// ----- design/eight_bit_cpu_alu_with_flags_core.sv -----
// 8-bit CPU ALU with Z/N/H/C flags: input register, datapath, result register.
// Each item passes through the input reg and then the result reg before its result transfer.
// Throughput: one item per cycle; the input stalls only when both regs are full.
// Reset (synchronous, active low) clears both valid bits; payload is not reset.
// Depends on ebalu_pkg and ebalu_exec.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_cpu_alu_with_flags_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  ebalu_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output ebalu_pkg::t_out_item o_out_item
);

    logic                 r_s1_valid;
    logic                 n_s1_valid;
    ebalu_pkg::t_in_item  r_s1_item;
    logic                 r_out_valid;
    logic                 n_out_valid;
    ebalu_pkg::t_out_item r_out_item;
    ebalu_pkg::t_out_item exec_item;
    logic                 out_ready;
    logic                 s1_ready;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign s1_ready  = !r_s1_valid || out_ready;

    assign n_s1_valid  = s1_ready ? i_in_valid : r_s1_valid;
    assign n_out_valid = out_ready ? r_s1_valid : r_out_valid;

    ebalu_exec u_exec (
        .i_item (r_s1_item),
        .o_item (exec_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_item <= i_in_item;
        end
        if (out_ready) begin
            r_out_item <= exec_item;
        end
    end

    assign o_in_stall  = !s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free register");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("input register lost a blocked item");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_ready) |=> o_out_valid)
        else $error("item did not reach the result register");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_valid)
        else $error("transfer not captured");

endmodule

`default_nettype wire
